FILE: hdl/smss_pkg.sv
// Package for the sorted matrix staircase search: sizes, payload types and state codes.
`default_nettype none

package smss_pkg;

  localparam int MAX_DIM  = 16;
  localparam int DIM_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W    = $clog2(MAX_DIM + 1);
  localparam int ADDR_W   = 2 * DIM_W;
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int CFG_W    = 5;
  localparam int IDX_W    = 4;
  localparam int SIZE_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int LDCMP_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int SIZE_RST = 16;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   col_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] search_key;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] found_row;
    logic [IDX_W-1:0] found_col;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/sorted_matrix_staircase_search.sv
// Top level of the sorted matrix staircase search: matrix memory, walk sequencer, result register.
`default_nettype none

// Holds a MAX_DIM x MAX_DIM matrix of signed 32-bit elements in a single-port-read memory and
// answers two kinds of request. A load request (req_type 0) writes one element in the cycle it
// is accepted, gives no result, and is dropped when its row or column is not below the active
// size (matrix_size, saturated at MAX_DIM). A search request (req_type 1) walks from the
// top-right corner of the active square: match stops the walk with found set, a cell greater
// than the key steps one column left, any other steps one row down, and leaving the square
// reports not found with row and column zero. The walk visits one cell per clock, paced by the
// registered memory read. The block is not ready while a walk runs, and a finished walk waits if
// the result register is still full. The memory is not cleared after reset: search only a
// square that has been loaded. matrix_size must be written only while idle; the block itself
// does not enforce this.
module sorted_matrix_staircase_search
  import smss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire req_t             in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rsp_t                  out_data
);

  // Configuration and active size
  logic [CFG_W-1:0] matrix_size;
  logic [CNT_W-1:0] n_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= CFG_W'(SIZE_RST);
    end else if (cfg_we) begin
      matrix_size <= cfg_data;
    end
  end

  // Saturate at MAX_DIM
  assign n_act = (SIZE_W'(matrix_size) > SIZE_W'(MAX_DIM)) ? CNT_W'(MAX_DIM)
                                                           : CNT_W'(matrix_size);

  // Walk state: r is the row, c is the column plus one so that zero means "left the square"
  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   r;
  logic [CNT_W-1:0]   r_next;
  logic [CNT_W-1:0]   c;
  logic [CNT_W-1:0]   c_next;
  logic signed [31:0] key;

  // Memory ports
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_en;

  logic in_acc;
  logic ld_in_range;
  logic in_square;
  logic hit;
  logic done;
  logic out_free;
  logic out_load;
  rsp_t res;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Loads outside the active square are dropped
  assign ld_in_range = (LDCMP_W'(in_data.row_index) < LDCMP_W'(n_act))
                    && (LDCMP_W'(in_data.col_index) < LDCMP_W'(n_act));
  assign wr_en   = in_acc && (in_data.req_type == REQ_LOAD) && ld_in_range;
  assign wr_addr = {DIM_W'(in_data.row_index), DIM_W'(in_data.col_index)};

  // One cell compare per cycle against the registered read data
  assign in_square = (r < n_act) && (c != '0);
  assign hit       = in_square && (rd_data == key);
  assign done      = (state == ST_WALK) && (!in_square || hit);
  assign out_load  = done && out_free;

  always_comb begin
    res.found     = hit;
    res.found_row = hit ? IDX_W'(r) : '0;
    res.found_col = hit ? IDX_W'(c - CNT_W'(1)) : '0;
  end

  always_comb begin
    state_next = state;
    r_next     = r;
    c_next     = c;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (in_data.req_type == REQ_SEARCH)) begin
          r_next     = '0;
          c_next     = n_act;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (done) begin
          // Hold the final cell until the result register frees up
          if (out_free) begin
            state_next = ST_IDLE;
          end
        end else if (rd_data > key) begin
          c_next = c - CNT_W'(1);
        end else begin
          r_next = r + CNT_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Address the cell of the next step; an out-of-square address reads a harmless entry
  assign rd_addr = {DIM_W'(r_next), DIM_W'(c_next - CNT_W'(1))};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.elem_value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    r <= r_next;
    c <= c_next;
    if (in_acc && (in_data.req_type == REQ_SEARCH)) begin
      key <= in_data.search_key;
    end
  end

  // Result register: load on a finished walk, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  // Checks
  a_walk_row_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (r <= n_act) && (c <= n_act))
    else $error("walk position beyond active square");

  a_result_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_WALK))
    else $error("result appeared without a walk");

  a_miss_zero_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> (out_data.found_row == '0) && (out_data.found_col == '0))
    else $error("not-found result carries a position");

  a_walk_ends_idle: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state == ST_IDLE) && out_valid)
    else $error("finished walk did not return to idle");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the sorted matrix staircase search block.
`timescale 1ns / 1ps

module testbench;
  import smss_pkg::*;

  localparam int HALF_PERIOD = 4;
  // Pause long enough for the longest walk, with a margin on top for draining.
  localparam int WALK_PAUSE  = 2 * MAX_DIM + 8;
  // Cycles with no handshake on either side before the run is declared hung.
  localparam int STALL_LIMIT = 5000;
  // Length of the one long receiver hold-off.
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 1200;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  req_t             in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  rsp_t             out_data;

  sorted_matrix_staircase_search uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Predictor state, updated as requests are accepted by the block.
  logic signed [31:0] mat_model [MAX_DIM][MAX_DIM];
  logic [CFG_W-1:0]   size_model = CFG_W'(SIZE_RST);
  rsp_t               walk_q[$];   // expected walk results, oldest first

  // Stimulus view of the matrix, updated as requests are queued. It lets the
  // generator pick keys that are actually stored.
  logic signed [31:0] plan_mat [MAX_DIM][MAX_DIM];
  int                 plan_n = MAX_DIM;
  req_t               pend_q[$];   // requests waiting for the driver
  int                 items_sent = 0;

  int err_count = 0;
  bit no_idle   = 1'b0;   // when set, neither side inserts gaps
  bit hold_go   = 1'b0;   // ask the receiver for its long hold-off

  // Active square size: matrix_size saturated at MAX_DIM.
  function automatic int active_dim(logic [CFG_W-1:0] s);
    return (s > MAX_DIM) ? MAX_DIM : int'(s);
  endfunction

  function automatic int idle_draw();
    return no_idle ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Walk from the top-right corner: stop on a match, step left when the cell
  // is greater than the key, otherwise step down; leaving the square misses.
  function automatic rsp_t staircase_walk(logic signed [31:0] key);
    int   n;
    int   r;
    int   c;
    rsp_t res;
    n   = active_dim(size_model);
    r   = 0;
    c   = n - 1;
    res = '0;
    while (r < n && c >= 0) begin
      if (mat_model[r][c] == key) begin
        res.found     = 1'b1;
        res.found_row = IDX_W'(r);
        res.found_col = IDX_W'(c);
        return res;
      end
      if (mat_model[r][c] > key) c--;
      else r++;
    end
    return res;
  endfunction

  // Apply one accepted request to the predictor: store a load that lands in
  // the square, queue the walk result of a search.
  task automatic apply_request(req_t q);
    int n;
    n = active_dim(size_model);
    if (q.req_type == REQ_LOAD) begin
      if (q.row_index < n && q.col_index < n)
        mat_model[q.row_index][q.col_index] = q.elem_value;
    end else begin
      walk_q.push_back(staircase_walk(q.search_key));
    end
  endtask

  // Queue a load; spare fields carry random noise.
  task automatic queue_load(int r, int c, logic signed [31:0] v);
    req_t q;
    q.req_type   = REQ_LOAD;
    q.row_index  = IDX_W'(r);
    q.col_index  = IDX_W'(c);
    q.elem_value = v;
    q.search_key = $urandom;
    pend_q.push_back(q);
    // Dropped loads change nothing and are not counted.
    if (r < plan_n && c < plan_n) begin
      plan_mat[r][c] = v;
      items_sent++;
    end
  endtask

  task automatic queue_search(logic signed [31:0] key);
    req_t q;
    q.req_type   = REQ_SEARCH;
    q.row_index  = IDX_W'($urandom);
    q.col_index  = IDX_W'($urandom);
    q.elem_value = $urandom;
    q.search_key = key;
    pend_q.push_back(q);
    items_sent++;
  endtask

  // Fill the active square with ascending rows and columns: each cell is at
  // least the larger of its upper and left neighbours, saturating at the top.
  task automatic load_sorted(longint base, int unsigned step_max);
    longint lo;
    longint v;
    for (int r = 0; r < plan_n; r++) begin
      for (int c = 0; c < plan_n; c++) begin
        if (r == 0 && c == 0) lo = base;
        else if (r == 0) lo = plan_mat[r][c-1];
        else if (c == 0) lo = plan_mat[r-1][c];
        else if (plan_mat[r-1][c] > plan_mat[r][c-1]) lo = plan_mat[r-1][c];
        else lo = plan_mat[r][c-1];
        v = (r == 0 && c == 0) ? lo : lo + longint'($urandom_range(0, step_max));
        if (v > longint'(VAL_MAX)) v = VAL_MAX;
        queue_load(r, c, 32'(v));
      end
    end
  endtask

  // Wait until nothing is pending or outstanding, then let any load that is
  // still in flight finish before touching the register.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pend_q.size() != 0 || in_valid || walk_q.size() != 0);
    repeat (WALK_PAUSE) @(negedge clk);
  endtask

  // Write matrix_size while the block is idle and mirror it in both views.
  task automatic set_size(int s);
    wait_quiet();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= CFG_W'(s);
    @(posedge clk);
    cfg_we     <= 1'b0;
    size_model  = CFG_W'(s);
    plan_n      = active_dim(CFG_W'(s));
  endtask

  // Request driver: hold the request until it is taken, then idle for the
  // gap drawn when it was launched before offering the next one.
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) apply_request(in_data);
      if (in_valid && !in_ready) begin
        // hold valid and payload until accepted
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pend_q.size() != 0) begin
        in_data  <= pend_q.pop_front();
        in_valid <= 1'b1;
        send_gap <= idle_draw();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: check each accepted result against the oldest walk
  // expectation, draw a stall after each one, and run the long hold-off once
  // when asked so that the block backs up onto its request side.
  int recv_gap  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    int   gap_next;
    bit   hold_now;
    rsp_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      gap_next = recv_gap;
      if (out_valid && out_ready) begin
        if (walk_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected result found=%0d row=%0d col=%0d", $realtime,
                     out_data.found, out_data.found_row, out_data.found_col);
        end else begin
          want = walk_q.pop_front();
          if (want.found !== out_data.found || want.found_row !== out_data.found_row ||
              want.found_col !== out_data.found_col) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: mismatch: expected found=%0d row=%0d col=%0d, got found=%0d row=%0d col=%0d",
                       $realtime, want.found, want.found_row, want.found_col,
                       out_data.found, out_data.found_row, out_data.found_col);
          end
        end
        gap_next = idle_draw();
      end else if (gap_next > 0) begin
        gap_next--;
      end
      hold_now = 1'b0;
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_now   = 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        hold_now   = (hold_left > 1);
      end
      recv_gap  <= gap_next;
      out_ready <= (gap_next == 0) && !hold_now;
    end
  end

  // Watchdog: end the run when neither side has moved for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: fill the whole store, directed cases, then random phases.
  initial begin
    int                 phase;
    int                 sz;
    int                 n;
    int                 k;
    int                 pick;
    int                 r;
    int                 c;
    int                 phase_items;
    int unsigned        step;
    logic signed [31:0] key;

    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Write every cell at the reset size so no walk reads an empty cell.
    plan_n = MAX_DIM;
    load_sorted(longint'(VAL_MIN), 32'd1 << 26);
    queue_load(MAX_DIM - 1, MAX_DIM - 1, VAL_MAX);

    // Extreme keys, the two other corners, an inner cell, a key just above it, zero.
    queue_search(VAL_MIN);
    queue_search(VAL_MAX);
    queue_search(plan_mat[0][MAX_DIM-1]);
    queue_search(plan_mat[MAX_DIM-1][0]);
    queue_search(plan_mat[7][9]);
    queue_search(plan_mat[7][9] + 32'sd1);
    queue_search(32'sd0);

    // Break the ordering in the middle, look for the odd cell, then restore it.
    key = plan_mat[8][8];
    queue_load(8, 8, VAL_MAX - 32'sd1);
    queue_search(VAL_MAX - 32'sd1);
    queue_load(8, 8, key);
    queue_search(key);

    // Size zero: the walk leaves the square at once and every load is dropped.
    set_size(0);
    queue_search(VAL_MIN);
    queue_load(0, 0, 32'sd5);

    // Above MAX_DIM: saturate to the full square.
    set_size(31);
    queue_search(plan_mat[MAX_DIM-1][MAX_DIM-1]);

    // One-cell square: hit, miss, and a load just outside it.
    set_size(1);
    queue_search(plan_mat[0][0]);
    queue_search(plan_mat[0][0] - 32'sd1);
    queue_load(1, 0, $urandom);
    queue_search(32'sd0);

    set_size(17);
    queue_search(plan_mat[3][12]);

    // Random phases: change the size, often refill the square in order, then
    // mostly searches for stored keys with some loads and noise mixed in.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      case (phase)
        1: sz = 16;
        2: sz = 16;
        3: sz = 2;
        4: sz = 0;
        5: sz = 31;
        6: sz = 1;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) sz = $urandom_range(MAX_DIM + 1, 31);
          else if (pick == 1) sz = 0;
          else sz = $urandom_range(1, MAX_DIM);
        end
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      set_size(sz);
      n = plan_n;

      // Phase two runs with the long receiver hold-off.
      if (phase == 2) hold_go = 1'b1;

      if (n > 0 && $urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0: step = 0;
          1: step = 1;
          2: step = 4;
          3: step = 1000;
          4: step = 32'd1 << 20;
          default: step = 32'd1 << 24;
        endcase
        load_sorted(longint'(VAL_MIN) + longint'($urandom_range(0, 32'h7fff_ffff)), step);
      end

      phase_items = $urandom_range(20, 60);
      for (k = 0; k < phase_items; k++) begin
        pick = $urandom_range(0, 99);
        r    = (n > 0) ? int'($urandom_range(0, n - 1)) : 0;
        c    = (n > 0) ? int'($urandom_range(0, n - 1)) : 0;
        if (pick < 65) begin
          pick = $urandom_range(0, 9);
          if (n > 0 && pick < 5) key = plan_mat[r][c];
          else if (n > 0 && pick < 7)
            key = plan_mat[r][c] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
          else if (pick == 9) key = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
          else key = $urandom;
          queue_search(key);
        end else if (n == 0) begin
          // nothing can be stored: drop-only noise
          queue_load($urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        end else if (pick < 90 || n >= MAX_DIM) begin
          // rewrite in place mostly, so the order survives; sometimes scramble
          if ($urandom_range(0, 3) == 0) queue_load(r, c, $urandom);
          else queue_load(r, c, plan_mat[r][c]);
        end else begin
          // outside the square on either axis
          if ($urandom_range(0, 1) == 0)
            queue_load($urandom_range(n, 15), $urandom_range(0, 15), $urandom);
          else
            queue_load($urandom_range(0, 15), $urandom_range(n, 15), $urandom);
        end
      end
    end

    wait_quiet();
    if (err_count == 0 && walk_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
